FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the frame stream monitor.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define RFSM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rfsm: assertion failed");

// Next-cycle implication, held off while reset is asserted
`define RFSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rfsm: assertion failed");

`endif

FILE: rtl/rfsm_pkg.sv
// ----------------------------------------------------------------------------
// rfsm_pkg
// Types, codes and helpers shared by the frame stream monitor modules.
// ----------------------------------------------------------------------------
package rfsm_pkg;

    // Field widths
    localparam int unsigned PAGE_W      = 12;
    localparam int unsigned PSN_W       = 20;
    localparam int unsigned FNUM_W      = 16;
    localparam int unsigned DROP_W      = 15;
    localparam int unsigned RING_W      = 13;
    localparam int unsigned CFG_IDX_W   = 2;

    // Nanoseconds per second
    localparam logic [29:0] NS_PER_S    = 30'd1000000000;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_PAGES = 2'd1;
    localparam logic [31:0]          RST_EXP_LEN    = 32'd4096;
    localparam logic [RING_W-1:0]    RST_RING_PAGES = 13'd64;

    // Event queue geometry
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_ERROR = 2'd1,
        CMD_OTHER = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Classified event kinds passed from front to back
    typedef enum logic [1:0] {
        EV_FRAME,
        EV_ERROR,
        EV_OTHER,
        EV_CLEAR
    } ev_kind_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_ADD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SQ,
        B_ACC,
        B_OUT
    } back_state_t;

    // One classified event
    typedef struct packed {
        ev_kind_t            kind;
        logic [63:0]         nbytes;
        logic                size_bad;
        logic                psn_bad;
        logic [DROP_W-1:0]   drop;
        logic                dt_valid;
        logic [63:0]         dt;
    } ev_t;

    // Snapshot of all statistics
    typedef struct packed {
        logic [63:0] frame_count;
        logic [63:0] byte_count;
        logic [63:0] dropped_count;
        logic [63:0] psn_mismatch_count;
        logic [63:0] size_error_count;
        logic [63:0] error_count;
        logic [63:0] other_opcode_count;
        logic [63:0] gap_count;
        logic [63:0] gap_min;
        logic [63:0] gap_max;
        logic [63:0] gap_sum;
        logic [63:0] gap_square_sum;
    } stats_t;

    localparam stats_t STATS_CLEAR = '{
        frame_count:        64'd0,
        byte_count:         64'd0,
        dropped_count:      64'd0,
        psn_mismatch_count: 64'd0,
        size_error_count:   64'd0,
        error_count:        64'd0,
        other_opcode_count: 64'd0,
        gap_count:          64'd0,
        gap_min:            {64{1'b1}},
        gap_max:            64'd0,
        gap_sum:            64'd0,
        gap_square_sum:     64'd0
    };

    // Add, pinning at all ones on carry out
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

FILE: rtl/rfsm_front.sv
// ----------------------------------------------------------------------------
// rfsm_front
// Accepts one completion beat, builds the ns timestamp and classifies it
// into an event for the back end. Owns the last frame number and time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfsm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [31:0]                   s_immediate,
    input  logic [31:0]                   s_meta_psn,
    input  logic [63:0]                   s_byte_len,
    input  logic [15:0]                   s_frame_seq,
    input  logic [31:0]                   s_ts_seconds,
    input  logic [29:0]                   s_ts_nanos,
    // Configuration
    input  logic [31:0]                   expected_len,
    input  logic [rfsm_pkg::RING_W-1:0]   ring_pages,
    // Event queue
    output logic                          push,
    output rfsm_pkg::ev_t                 push_ev,
    input  logic                          queue_full
);

    rfsm_pkg::front_state_t state_reg, state_next;

    // Held beat
    logic [1:0]                    cmd_reg;
    logic [31:0]                   imm_reg;
    logic [31:0]                   psn_reg;
    logic [63:0]                   nbytes_reg;
    logic [rfsm_pkg::FNUM_W-1:0]   fnum_reg;
    logic [31:0]                   sec_reg;
    logic [29:0]                   nanos_reg;

    // Timestamp pipeline
    logic [61:0]                   prod_reg;
    logic [63:0]                   ts_reg;

    // Last-value trackers
    logic                          last_num_valid_reg;
    logic [rfsm_pkg::FNUM_W-1:0]   last_num_reg;
    logic                          last_time_valid_reg;
    logic [63:0]                   last_time_reg;

    logic                          accept;
    logic                          page_bad;
    logic [rfsm_pkg::FNUM_W-1:0]   gap;
    logic [64:0]                   diff;
    logic                          good_frame;

    assign accept = s_valid && s_ready;

    // Sequence one beat: accept, multiply, add, classify
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            rfsm_pkg::F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = rfsm_pkg::F_MUL;
                end
            end
            rfsm_pkg::F_MUL: begin
                state_next = rfsm_pkg::F_ADD;
            end
            rfsm_pkg::F_ADD: begin
                state_next = rfsm_pkg::F_PUSH;
            end
            rfsm_pkg::F_PUSH: begin
                if (!queue_full) begin
                    push       = 1'b1;
                    state_next = rfsm_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = rfsm_pkg::F_IDLE;
            end
        endcase
    end

    // Classify the held beat
    always_comb begin
        page_bad   = {1'b0, imm_reg[rfsm_pkg::PAGE_W-1:0]} >= ring_pages;
        gap        = fnum_reg - last_num_reg - rfsm_pkg::FNUM_W'(1);
        diff       = {1'b0, ts_reg} - {1'b0, last_time_reg};
        good_frame = (cmd_reg == rfsm_pkg::CMD_FRAME) && !page_bad;

        push_ev.nbytes   = nbytes_reg;
        push_ev.size_bad = nbytes_reg != {32'd0, expected_len};
        push_ev.psn_bad  = psn_reg[rfsm_pkg::PSN_W-1:0] !=
                           imm_reg[31:rfsm_pkg::PAGE_W];
        // Only a gap from one up to 32767 (below half the number space) counts as drops
        push_ev.drop     = (last_num_valid_reg && !gap[rfsm_pkg::FNUM_W-1])
                           ? gap[rfsm_pkg::DROP_W-1:0] : '0;
        push_ev.dt_valid = last_time_valid_reg && !diff[64] && (diff[63:0] != 64'd0);
        push_ev.dt       = diff[63:0];

        case (cmd_reg)
            rfsm_pkg::CMD_FRAME: push_ev.kind = page_bad ? rfsm_pkg::EV_ERROR
                                                         : rfsm_pkg::EV_FRAME;
            rfsm_pkg::CMD_ERROR: push_ev.kind = rfsm_pkg::EV_ERROR;
            rfsm_pkg::CMD_OTHER: push_ev.kind = rfsm_pkg::EV_OTHER;
            default:             push_ev.kind = rfsm_pkg::EV_CLEAR;
        endcase
    end

    // Control state and trackers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= rfsm_pkg::F_IDLE;
            last_num_valid_reg  <= 1'b0;
            last_num_reg        <= '0;
            last_time_valid_reg <= 1'b0;
            last_time_reg       <= 64'd0;
        end else begin
            state_reg <= state_next;
            if (push) begin
                if (cmd_reg == rfsm_pkg::CMD_CLEAR) begin
                    last_num_valid_reg  <= 1'b0;
                    last_num_reg        <= '0;
                    last_time_valid_reg <= 1'b0;
                    last_time_reg       <= 64'd0;
                end else if (good_frame) begin
                    last_num_valid_reg  <= 1'b1;
                    last_num_reg        <= fnum_reg;
                    last_time_valid_reg <= 1'b1;
                    last_time_reg       <= ts_reg;
                end
            end
        end
    end

    // Payload: hold the beat and build the timestamp
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_cmd;
            imm_reg    <= s_immediate;
            psn_reg    <= s_meta_psn;
            nbytes_reg <= s_byte_len;
            fnum_reg   <= s_frame_seq;
            sec_reg    <= s_ts_seconds;
            nanos_reg  <= s_ts_nanos;
        end
        if (state_reg == rfsm_pkg::F_MUL) begin
            prod_reg <= {30'd0, sec_reg} * {32'd0, rfsm_pkg::NS_PER_S};
        end
        if (state_reg == rfsm_pkg::F_ADD) begin
            ts_reg <= {2'b00, prod_reg} + {34'd0, nanos_reg};
        end
    end

    `RFSM_ASSERT_NEXT(a_front_one_beat, aclk, aresetn, accept, !s_ready)
    `RFSM_ASSERT_NOW(a_front_push_room, aclk, aresetn, push, !queue_full && !s_ready)

endmodule

FILE: rtl/rfsm_queue.sv
// ----------------------------------------------------------------------------
// rfsm_queue
// Short event queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfsm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rfsm_pkg::ev_t  push_ev,
    output logic           full,
    input  logic           pop,
    output rfsm_pkg::ev_t  pop_ev,
    output logic           empty
);

    rfsm_pkg::ev_t                       slot_reg [rfsm_pkg::QUEUE_DEPTH];
    logic [rfsm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [rfsm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [rfsm_pkg::QUEUE_CNT_W-1:0]    count_reg;

    assign full   = count_reg == rfsm_pkg::QUEUE_CNT_W'(rfsm_pkg::QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign pop_ev = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + rfsm_pkg::QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rfsm_pkg::QUEUE_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + rfsm_pkg::QUEUE_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - rfsm_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

    // Store the pushed event
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_ev;
        end
    end

    `RFSM_ASSERT_NOW(a_queue_no_overflow, aclk, aresetn, push, !full)
    `RFSM_ASSERT_NOW(a_queue_no_underflow, aclk, aresetn, pop, !empty)

endmodule

FILE: rtl/rfsm_back.sv
// ----------------------------------------------------------------------------
// rfsm_back
// Applies classified events to the statistics and publishes a snapshot
// of them through the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfsm_back (
    input  logic             aclk,
    input  logic             aresetn,
    // Event queue
    output logic             pop,
    input  rfsm_pkg::ev_t    pop_ev,
    input  logic             queue_empty,
    // Result channel
    output logic             m_valid,
    input  logic             m_ready,
    output rfsm_pkg::stats_t m_stats
);

    rfsm_pkg::back_state_t state_reg, state_next;
    rfsm_pkg::ev_t         ev_reg;
    logic [63:0]           sq_reg;
    rfsm_pkg::stats_t      stats_reg, stats_next;
    rfsm_pkg::stats_t      out_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;
    logic                  load_out;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_stats  = out_reg;

    // Sequence one event: pop, square, accumulate, publish
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            rfsm_pkg::B_IDLE: begin
                if (!queue_empty) begin
                    pop        = 1'b1;
                    state_next = rfsm_pkg::B_SQ;
                end
            end
            rfsm_pkg::B_SQ: begin
                state_next = rfsm_pkg::B_ACC;
            end
            rfsm_pkg::B_ACC: begin
                state_next = rfsm_pkg::B_OUT;
            end
            rfsm_pkg::B_OUT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = rfsm_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = rfsm_pkg::B_IDLE;
            end
        endcase
        m_valid_next = load_out || (m_valid_reg && !m_ready);
    end

    // Update the statistics for the held event
    always_comb begin
        stats_next = stats_reg;
        case (ev_reg.kind)
            rfsm_pkg::EV_FRAME: begin
                stats_next.frame_count        = stats_reg.frame_count + 64'd1;
                stats_next.byte_count         = stats_reg.byte_count + ev_reg.nbytes;
                stats_next.size_error_count   = stats_reg.size_error_count
                                                + {63'd0, ev_reg.size_bad};
                stats_next.psn_mismatch_count = stats_reg.psn_mismatch_count
                                                + {63'd0, ev_reg.psn_bad};
                stats_next.dropped_count      = stats_reg.dropped_count
                                                + {49'd0, ev_reg.drop};
                if (ev_reg.dt_valid) begin
                    stats_next.gap_count      = stats_reg.gap_count + 64'd1;
                    stats_next.gap_sum        = rfsm_pkg::sat_add(stats_reg.gap_sum, ev_reg.dt);
                    stats_next.gap_square_sum = rfsm_pkg::sat_add(stats_reg.gap_square_sum,
                                                                  sq_reg);
                    if (ev_reg.dt < stats_reg.gap_min) begin
                        stats_next.gap_min = ev_reg.dt;
                    end
                    if (ev_reg.dt > stats_reg.gap_max) begin
                        stats_next.gap_max = ev_reg.dt;
                    end
                end
            end
            rfsm_pkg::EV_ERROR: begin
                stats_next.error_count = stats_reg.error_count + 64'd1;
            end
            rfsm_pkg::EV_OTHER: begin
                stats_next.other_opcode_count = stats_reg.other_opcode_count + 64'd1;
            end
            default: begin
                stats_next = rfsm_pkg::STATS_CLEAR;
            end
        endcase
    end

    // Control state and statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rfsm_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
            stats_reg   <= rfsm_pkg::STATS_CLEAR;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == rfsm_pkg::B_ACC) begin
                stats_reg <= stats_next;
            end
        end
    end

    // Payload: event, square and output snapshot
    always_ff @(posedge aclk) begin
        if (pop) begin
            ev_reg <= pop_ev;
        end
        if (state_reg == rfsm_pkg::B_SQ) begin
            // Square pins at all ones once the interval leaves 32 bits
            sq_reg <= (ev_reg.dt[63:32] != 32'd0) ? {64{1'b1}}
                      : ({32'd0, ev_reg.dt[31:0]} * {32'd0, ev_reg.dt[31:0]});
        end
        if (load_out) begin
            out_reg <= stats_reg;
        end
    end

    `RFSM_ASSERT_NEXT(a_back_publish, aclk, aresetn, load_out, m_valid_reg)
    `RFSM_ASSERT_NOW(a_back_min_max, aclk, aresetn, stats_reg.gap_count != 64'd0,
                     stats_reg.gap_min <= stats_reg.gap_max)

endmodule

FILE: rtl/rdma_frame_stream_monitor_top.sv
// ----------------------------------------------------------------------------
// rdma_frame_stream_monitor_top
// Running statistics over a received RDMA frame stream.
// ----------------------------------------------------------------------------
// Each accepted beat is one completion event and yields one result beat: a
// snapshot of all twelve statistics after the event. The front end takes
// each beat through accept, seconds-to-ns multiply, add and classify into
// the queue, and takes no new beat until it has pushed the last; the back
// end takes each event through pop, interval square, accumulate and
// publish, holding while the output is stalled. A two-entry queue lets them
// overlap. Configuration writes take effect at once and are meant to be
// made while the block is idle.
// ----------------------------------------------------------------------------
module rdma_frame_stream_monitor_top (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    // Input channel
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_cmd,
    input  logic [31:0]   s_immediate,
    input  logic [31:0]   s_meta_psn,
    input  logic [63:0]   s_byte_len,
    input  logic [15:0]   s_frame_seq,
    input  logic [31:0]   s_ts_seconds,
    input  logic [29:0]   s_ts_nanos,
    // Result channel
    output logic          m_valid,
    input  logic          m_ready,
    output logic [63:0]   m_frame_count,
    output logic [63:0]   m_byte_count,
    output logic [63:0]   m_dropped_count,
    output logic [63:0]   m_psn_mismatch_count,
    output logic [63:0]   m_size_error_count,
    output logic [63:0]   m_error_count,
    output logic [63:0]   m_other_opcode_count,
    output logic [63:0]   m_gap_count,
    output logic [63:0]   m_gap_min,
    output logic [63:0]   m_gap_max,
    output logic [63:0]   m_gap_sum,
    output logic [63:0]   m_gap_square_sum
);

    logic [31:0]                   exp_len_reg;
    logic [rfsm_pkg::RING_W-1:0]   ring_pages_reg;

    logic                          push;
    logic                          pop;
    logic                          queue_full;
    logic                          queue_empty;
    rfsm_pkg::ev_t                 push_ev;
    rfsm_pkg::ev_t                 pop_ev;
    rfsm_pkg::stats_t              stats;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_len_reg    <= rfsm_pkg::RST_EXP_LEN;
            ring_pages_reg <= rfsm_pkg::RST_RING_PAGES;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rfsm_pkg::REG_EXP_LEN:    exp_len_reg    <= cfg_data;
                rfsm_pkg::REG_RING_PAGES: ring_pages_reg <= cfg_data[rfsm_pkg::RING_W-1:0];
                default: ;
            endcase
        end
    end

    rfsm_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_immediate         (s_immediate),
        .s_meta_psn          (s_meta_psn),
        .s_byte_len          (s_byte_len),
        .s_frame_seq         (s_frame_seq),
        .s_ts_seconds        (s_ts_seconds),
        .s_ts_nanos          (s_ts_nanos),
        .expected_len        (exp_len_reg),
        .ring_pages          (ring_pages_reg),
        .push                (push),
        .push_ev             (push_ev),
        .queue_full          (queue_full)
    );

    rfsm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_ev (push_ev),
        .full    (queue_full),
        .pop     (pop),
        .pop_ev  (pop_ev),
        .empty   (queue_empty)
    );

    rfsm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop         (pop),
        .pop_ev      (pop_ev),
        .queue_empty (queue_empty),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_stats     (stats)
    );

    // Fan the snapshot out to the result ports
    assign m_frame_count        = stats.frame_count;
    assign m_byte_count         = stats.byte_count;
    assign m_dropped_count      = stats.dropped_count;
    assign m_psn_mismatch_count = stats.psn_mismatch_count;
    assign m_size_error_count   = stats.size_error_count;
    assign m_error_count        = stats.error_count;
    assign m_other_opcode_count = stats.other_opcode_count;
    assign m_gap_count          = stats.gap_count;
    assign m_gap_min            = stats.gap_min;
    assign m_gap_max            = stats.gap_max;
    assign m_gap_sum            = stats.gap_sum;
    assign m_gap_square_sum     = stats.gap_square_sum;

endmodule
